/* design/kpi_pkg.sv */
// Shared types and constants for the keyframe position interpolator.
// Request/response payloads, table entry layout, sequencer states and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kpi_pkg;

   localparam int TIME_W   = 24;
   localparam int POS_W    = 32;
   localparam int INDEX_W  = 6;
   localparam int SEG_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Ratio is unsigned Q0.16 with room for exactly 1.0
   localparam int RATIO_W   = 17;
   localparam int DIV_STEPS = 16;
   localparam int DIVCNT_W  = 5;
   localparam int REM_W     = TIME_W + 1;
   localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'h10000;
   localparam logic [RATIO_W-1:0] RATIO_ZERO = 17'h00000;

   // (p1 - p0) is 33 bits signed, times the ratio as 18 bits signed
   localparam int DIFF_W = POS_W + 1;
   localparam int PROD_W = DIFF_W + RATIO_W + 1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INTERP  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SINGLE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef struct packed {
      logic                      op;
      logic [INDEX_W-1:0]        key_index;
      logic [TIME_W-1:0]         key_time;
      logic signed [POS_W-1:0]   key_x;
      logic signed [POS_W-1:0]   key_y;
      logic signed [POS_W-1:0]   key_z;
      logic [TIME_W-1:0]         query_time;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic [SEG_W-1:0]          segment;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]         key_time;
      logic signed [POS_W-1:0]   key_x;
      logic signed [POS_W-1:0]   key_y;
      logic signed [POS_W-1:0]   key_z;
   } key_entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DIV,
      S_DIV_WAIT,
      S_MUL,
      S_ACC,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

/* design/keyframe_position_interpolator.sv */
// Keyframe position interpolator. A write request stores one keyframe (time and
// x/y/z position) in the table RAM and is answered with a written status. A query
// request walks the table from entry 0, one RAM read state and one compare state
// per entry, until it finds the first key after entry 0 whose time exceeds the
// query time, or reaches the last loaded key; the serial divider then forms the
// Q0.16 ratio (no division runs when the ratio clamps), and the shared multiplier
// produces x, y and z in turn. An empty table is answered without a walk and a
// single key after reading entry 0. The RAM read port sets the walk time. Only one
// request is in work at a time; a finished response waits in an output register,
// so the next request is taken while it is still pending.
// Program key_count through the csr port only while no request is in flight;
// table entries below key_count must have been written before a query.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_position_interpolator #(
   parameter int MAX_KEYS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire kpi_pkg::req_type                 req_payload,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      kpi_pkg::rsp_type                 rsp_payload,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [kpi_pkg::COUNT_W-1:0]      csr_data
);

   localparam int ADDR_W = $clog2(MAX_KEYS);
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);

   kpi_pkg::state_type                  state_ff, state_in;

   // control
   logic [kpi_pkg::COUNT_W-1:0]         key_count_ff;
   logic                                rsp_valid_ff;
   kpi_pkg::rsp_type                    rsp_payload_ff;

   // request in work
   logic [kpi_pkg::TIME_W-1:0]          query_time_ff;
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    idx_ff;
   logic [1:0]                          comp_ff;
   logic [kpi_pkg::STATUS_W-1:0]        status_ff;
   logic [kpi_pkg::SEG_W-1:0]           seg_ff;
   kpi_pkg::key_entry_type              lo_ff;
   kpi_pkg::key_entry_type              hi_ff;
   logic signed [kpi_pkg::POS_W-1:0]    pos_ff [3];

   logic                                req_fire;
   logic                                rsp_free;
   logic [CNT_W-1:0]                    count_clamped;
   logic                                last_key;
   logic                                seg_found;

   // RAM
   logic                                ram_wr_en;
   logic [ADDR_W-1:0]                   ram_wr_addr;
   logic [ADDR_W-1:0]                   ram_rd_addr;
   kpi_pkg::key_entry_type              ram_wr_data;
   kpi_pkg::key_entry_type              ram_rd_data;

   // arithmetic units
   logic                                ratio_start;
   logic                                ratio_done;
   logic [kpi_pkg::RATIO_W-1:0]         ratio;
   logic signed [kpi_pkg::POS_W-1:0]    mul_lo;
   logic signed [kpi_pkg::POS_W-1:0]    mul_hi;
   logic signed [kpi_pkg::PROD_W-1:0]   product;

   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // a count above the table size acts as the table size
   assign count_clamped = (32'(key_count_ff) > MAX_KEYS) ? CNT_W'(MAX_KEYS)
                                                         : CNT_W'(key_count_ff);

   assign last_key  = (idx_ff == count_ff - CNT_W'(1));
   assign seg_found = (ram_rd_data.key_time > query_time_ff);

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kpi_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_payload.op == kpi_pkg::OP_WRITE || count_clamped == CNT_W'(0)) begin
                  state_in = kpi_pkg::S_OUT;
               end else begin
                  state_in = kpi_pkg::S_READ;
               end
            end
         end
         kpi_pkg::S_READ: begin
            state_in = kpi_pkg::S_CHECK;
         end
         kpi_pkg::S_CHECK: begin
            if (count_ff == CNT_W'(1)) begin
               state_in = kpi_pkg::S_OUT;
            end else if (idx_ff != CNT_W'(0) && (seg_found || last_key)) begin
               state_in = kpi_pkg::S_DIV;
            end else begin
               state_in = kpi_pkg::S_READ;
            end
         end
         kpi_pkg::S_DIV: begin
            state_in = kpi_pkg::S_DIV_WAIT;
         end
         kpi_pkg::S_DIV_WAIT: begin
            if (ratio_done) begin
               state_in = kpi_pkg::S_MUL;
            end
         end
         kpi_pkg::S_MUL: begin
            state_in = kpi_pkg::S_ACC;
         end
         kpi_pkg::S_ACC: begin
            if (comp_ff == kpi_pkg::COMP_Z) begin
               state_in = kpi_pkg::S_OUT;
            end else begin
               state_in = kpi_pkg::S_MUL;
            end
         end
         kpi_pkg::S_OUT: begin
            if (rsp_free) begin
               state_in = kpi_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kpi_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_ready   = 1'b0;
      ratio_start = 1'b0;
      unique case (state_ff)
         kpi_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         kpi_pkg::S_DIV: begin
            ratio_start = 1'b1;
         end
         kpi_pkg::S_READ, kpi_pkg::S_CHECK, kpi_pkg::S_DIV_WAIT,
         kpi_pkg::S_MUL, kpi_pkg::S_ACC, kpi_pkg::S_OUT: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Store a keyframe on the accept edge; drop writes past the table
   assign ram_wr_en   = req_fire && (req_payload.op == kpi_pkg::OP_WRITE)
                        && (32'(req_payload.key_index) < MAX_KEYS);
   assign ram_wr_addr = ADDR_W'(req_payload.key_index);
   assign ram_wr_data = '{key_time: req_payload.key_time,
                          key_x:    req_payload.key_x,
                          key_y:    req_payload.key_y,
                          key_z:    req_payload.key_z};
   assign ram_rd_addr = idx_ff[ADDR_W-1:0];

   kpi_ram #(
      .WIDTH ($bits(kpi_pkg::key_entry_type)),
      .DEPTH (MAX_KEYS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kpi_ratio u_ratio (
      .clock      (clock),
      .reset      (reset),
      .start      (ratio_start),
      .query_time (query_time_ff),
      .time_lo    (lo_ff.key_time),
      .time_hi    (hi_ff.key_time),
      .done       (ratio_done),
      .ratio      (ratio)
   );

   // select the component fed to the shared multiplier
   always_comb begin
      case (comp_ff)
         kpi_pkg::COMP_X: begin
            mul_lo = lo_ff.key_x;
            mul_hi = hi_ff.key_x;
         end
         kpi_pkg::COMP_Y: begin
            mul_lo = lo_ff.key_y;
            mul_hi = hi_ff.key_y;
         end
         default: begin
            mul_lo = lo_ff.key_z;
            mul_hi = hi_ff.key_z;
         end
      endcase
   end

   kpi_mul u_mul (
      .clock   (clock),
      .pos_lo  (mul_lo),
      .pos_hi  (mul_hi),
      .ratio   (ratio),
      .product (product)
   );

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpi_pkg::S_IDLE;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            key_count_ff <= csr_data;
         end
         if (state_ff == kpi_pkg::S_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         kpi_pkg::S_IDLE: begin
            if (req_fire) begin
               query_time_ff <= req_payload.query_time;
               count_ff      <= count_clamped;
               idx_ff        <= '0;
               comp_ff       <= kpi_pkg::COMP_X;
               seg_ff        <= '0;
               pos_ff[0]     <= '0;
               pos_ff[1]     <= '0;
               pos_ff[2]     <= '0;
               if (req_payload.op == kpi_pkg::OP_WRITE) begin
                  status_ff <= kpi_pkg::STATUS_WRITTEN;
               end else if (count_clamped == CNT_W'(0)) begin
                  status_ff <= kpi_pkg::STATUS_EMPTY;
               end else if (count_clamped == CNT_W'(1)) begin
                  status_ff <= kpi_pkg::STATUS_SINGLE;
               end else begin
                  status_ff <= kpi_pkg::STATUS_INTERP;
               end
            end
         end
         kpi_pkg::S_CHECK: begin
            if (count_ff == CNT_W'(1)) begin
               pos_ff[0] <= ram_rd_data.key_x;
               pos_ff[1] <= ram_rd_data.key_y;
               pos_ff[2] <= ram_rd_data.key_z;
            end else if (idx_ff != CNT_W'(0) && (seg_found || last_key)) begin
               // segment ends here: keep the previous entry as its lower key
               hi_ff  <= ram_rd_data;
               seg_ff <= kpi_pkg::SEG_W'(idx_ff - CNT_W'(1));
            end else begin
               lo_ff  <= ram_rd_data;
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         kpi_pkg::S_ACC: begin
            // floor(product / 2^16), only the low 32 bits survive
            pos_ff[comp_ff] <= mul_lo + product[kpi_pkg::POS_W+15:16];
            comp_ff         <= comp_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == kpi_pkg::S_OUT && rsp_free) begin
         rsp_payload_ff <= '{status:  status_ff,
                             pos_x:   pos_ff[0],
                             pos_y:   pos_ff[1],
                             pos_z:   pos_ff[2],
                             segment: seg_ff};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* design/kpi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the keyframe table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/kpi_ratio.sv */
// Serial ratio unit: (t - t0) / (t1 - t0) in unsigned Q0.16, clamped to 0..1.
// One quotient bit per cycle, restoring division. Uses kpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpi_ratio (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [kpi_pkg::TIME_W-1:0]    query_time,
   input  wire logic [kpi_pkg::TIME_W-1:0]    time_lo,
   input  wire logic [kpi_pkg::TIME_W-1:0]    time_hi,
   output      logic                          done,
   output      logic [kpi_pkg::RATIO_W-1:0]   ratio
);

   logic                            busy_ff, busy_in;
   logic [kpi_pkg::DIVCNT_W-1:0]    count_ff, count_in;
   logic [kpi_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [kpi_pkg::TIME_W-1:0]      gap_ff, gap_in;
   logic [kpi_pkg::RATIO_W-1:0]     quo_ff, quo_in;
   logic [kpi_pkg::REM_W-1:0]       shifted;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      gap_in   = gap_ff;
      quo_in   = quo_ff;
      shifted  = {rem_ff[kpi_pkg::REM_W-2:0], 1'b0};
      if (start) begin
         if (time_hi <= time_lo || query_time >= time_hi) begin
            quo_in  = kpi_pkg::RATIO_ONE;
            busy_in = 1'b0;
         end else if (query_time <= time_lo) begin
            quo_in  = kpi_pkg::RATIO_ZERO;
            busy_in = 1'b0;
         end else begin
            rem_in   = {1'b0, query_time - time_lo};
            gap_in   = time_hi - time_lo;
            quo_in   = kpi_pkg::RATIO_ZERO;
            count_in = kpi_pkg::DIVCNT_W'(kpi_pkg::DIV_STEPS);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         // remainder stays below the gap, so the shifted value fits
         if (shifted >= {1'b0, gap_ff}) begin
            rem_in = shifted - {1'b0, gap_ff};
            quo_in = {quo_ff[kpi_pkg::RATIO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[kpi_pkg::RATIO_W-2:0], 1'b0};
         end
         count_in = count_ff - kpi_pkg::DIVCNT_W'(1);
         busy_in  = (count_ff != kpi_pkg::DIVCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      gap_ff   <= gap_in;
      quo_ff   <= quo_in;
   end

   assign done  = !busy_ff;
   assign ratio = quo_ff;

endmodule

`default_nettype wire

/* design/kpi_mul.sv */
// Shared multiplier: registers (p1 - p0) * ratio for one component at a time.
// Uses kpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpi_mul (
   input  wire logic                               clock,
   input  wire logic signed [kpi_pkg::POS_W-1:0]   pos_lo,
   input  wire logic signed [kpi_pkg::POS_W-1:0]   pos_hi,
   input  wire logic [kpi_pkg::RATIO_W-1:0]        ratio,
   output      logic signed [kpi_pkg::PROD_W-1:0]  product
);

   logic signed [kpi_pkg::DIFF_W-1:0]    diff;
   logic signed [kpi_pkg::RATIO_W:0]     ratio_s;
   logic signed [kpi_pkg::PROD_W-1:0]    product_in;
   logic signed [kpi_pkg::PROD_W-1:0]    product_ff;

   always_comb begin
      diff       = {pos_hi[kpi_pkg::POS_W-1], pos_hi} - {pos_lo[kpi_pkg::POS_W-1], pos_lo};
      ratio_s    = {1'b0, ratio};
      product_in = diff * ratio_s;
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

/* design/kpi_checker.sv */
// Port-level checker for the keyframe position interpolator, bound to the top.
// Uses kpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpi_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire kpi_pkg::rsp_type              rsp_payload
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while another is in work");

   // every response answers an accepted request; at most two are pending
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || pending_ff != 2'd0) && pending_ff != 2'd3)
      else $error("response count does not match request count");

   // writes and empty-table queries carry no position or segment
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == kpi_pkg::STATUS_WRITTEN ||
                    rsp_payload.status == kpi_pkg::STATUS_EMPTY)
      |-> rsp_payload.pos_x == '0 && rsp_payload.pos_y == '0 &&
          rsp_payload.pos_z == '0 && rsp_payload.segment == '0)
      else $error("non-zero payload on write or empty response");

   // single-key answers report segment zero
   a_single_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == kpi_pkg::STATUS_SINGLE
      |-> rsp_payload.segment == '0)
      else $error("single-key response with non-zero segment");

endmodule

bind keyframe_position_interpolator kpi_checker u_kpi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
